@@ design/mtc_pkg.sv @@
// ----------------------------------------------------------------------------
// mtc_pkg: shared types and constants of the matrix transposition cipher
// Field widths, register indexes, command codes and the side clamp used by
// the register file, the walk address generator and the top level.
// ----------------------------------------------------------------------------
package mtc_pkg;

  // matrix and buffer sizes
  localparam int MAX_SIDE  = 64;
  localparam int MAX_CELLS = 4096;

  localparam int SIDE_W  = 7;                    // key register width, holds MAX_SIDE
  localparam int COORD_W = $clog2(MAX_SIDE);     // column / row index
  localparam int ADDR_W  = $clog2(MAX_CELLS);    // buffer address
  localparam int CNT_W   = ADDR_W + 1;           // byte count, holds MAX_CELLS
  localparam int DATA_W  = 8;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd2;

  // item commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef logic [SIDE_W-1:0] side_t;

  typedef struct packed {
    side_t width;
    side_t height;
    logic  decipher;
  } mtc_cfg_t;

  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] data_in;
    logic              stream_end;
  } mtc_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              out_valid;
    logic              block_last;
    logic              rejected;
  } mtc_out_t;

  // block parameters handed to the walk generator at block close
  typedef struct packed {
    side_t            width;
    side_t            height;
    logic             decipher;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cells;
  } mtc_walk_cfg_t;

  // one buffer-to-buffer move issued by the walk generator
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
  } mtc_walk_step_t;

  // a key of zero acts as one, a key above MAX_SIDE acts as MAX_SIDE
  function automatic side_t clamp_side(input side_t v);
    side_t r;
    r = v;
    if (v == '0) begin
      r = side_t'(1);
    end else if (v > side_t'(MAX_SIDE)) begin
      r = side_t'(MAX_SIDE);
    end
    return r;
  endfunction

endpackage

@@ design/mtc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mtc_cfg_regs: configuration register file
// Holds the matrix width, matrix height and decipher mode behind an APB-style
// port. Writes land in the access phase, reads return the stored value.
// ----------------------------------------------------------------------------
module mtc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtc_pkg::PADDR_W-1:0]   paddr,
  input  logic [mtc_pkg::PDATA_W-1:0]   pwdata,
  output logic [mtc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output mtc_pkg::mtc_cfg_t             cfg_o
);
  import mtc_pkg::*;

  mtc_cfg_t              cfg_q, cfg_d;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  cfg_d.width    = pwdata[SIDE_W-1:0];
        REG_HEIGHT: cfg_d.height   = pwdata[SIDE_W-1:0];
        REG_MODE:   cfg_d.decipher = pwdata[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= side_t'(8);
      cfg_q.height   <= side_t'(8);
      cfg_q.decipher <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // register read decode
  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = PDATA_W'(cfg_q.width);
      REG_HEIGHT: prdata = PDATA_W'(cfg_q.height);
      REG_MODE:   prdata = PDATA_W'(cfg_q.decipher);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/mtc_walk.sv @@
// ----------------------------------------------------------------------------
// mtc_walk: route walk address generator
// Steps column-outer, row-inner over the matrix, one position per cycle,
// keeping (c+r) mod width and the row base as running values. Positions at
// or beyond the loaded count are skipped; each kept one issues a move.
// ----------------------------------------------------------------------------
module mtc_walk (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  mtc_pkg::mtc_walk_cfg_t  cfg_i,
  output logic                    busy_o,
  output mtc_pkg::mtc_walk_step_t step_o
);
  import mtc_pkg::*;

  logic                busy_q, busy_d;
  logic [COORD_W-1:0]  col_q, col_d;
  logic [COORD_W-1:0]  row_q, row_d;
  logic [COORD_W-1:0]  colmod_q, colmod_d;
  logic [ADDR_W-1:0]   rowbase_q, rowbase_d;
  logic [CNT_W-1:0]    seq_q, seq_d;
  logic [COORD_W-1:0]  last_col_q, last_col_d;
  logic [COORD_W-1:0]  last_row_q, last_row_d;
  logic [ADDR_W-1:0]   rowtop_q, rowtop_d;
  side_t               width_q, width_d;
  logic                mode_q, mode_d;
  logic [CNT_W-1:0]    count_q, count_d;

  logic [ADDR_W-1:0]   pos;
  logic                take;
  logic [CNT_W-1:0]    rowtop_full;
  side_t               width_m1;
  side_t               height_m1;

  // current walk position and whether it holds a loaded byte
  assign pos  = ADDR_W'(colmod_q) + rowbase_q;
  assign take = busy_q && ({1'b0, pos} < count_q) && (seq_q < count_q);

  always_comb begin
    step_o.valid   = take;
    step_o.rd_addr = mode_q ? seq_q[ADDR_W-1:0] : pos;
    step_o.wr_addr = mode_q ? pos : seq_q[ADDR_W-1:0];
  end

  // start values: top row base is width*height - width
  assign rowtop_full = cfg_i.cells - CNT_W'(cfg_i.width);
  assign width_m1    = cfg_i.width - side_t'(1);
  assign height_m1   = cfg_i.height - side_t'(1);

  // sequencer
  always_comb begin
    busy_d     = busy_q;
    col_d      = col_q;
    row_d      = row_q;
    colmod_d   = colmod_q;
    rowbase_d  = rowbase_q;
    seq_d      = seq_q;
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    rowtop_d   = rowtop_q;
    width_d    = width_q;
    mode_d     = mode_q;
    count_d    = count_q;
    if (start_i) begin
      busy_d     = 1'b1;
      col_d      = '0;
      row_d      = '0;
      colmod_d   = '0;
      seq_d      = '0;
      rowtop_d   = rowtop_full[ADDR_W-1:0];
      rowbase_d  = rowtop_full[ADDR_W-1:0];
      last_col_d = width_m1[COORD_W-1:0];
      last_row_d = height_m1[COORD_W-1:0];
      width_d    = cfg_i.width;
      mode_d     = cfg_i.decipher;
      count_d    = cfg_i.count;
    end else if (busy_q) begin
      if (take) begin
        seq_d = seq_q + CNT_W'(1);
      end
      if (row_q == last_row_q) begin
        // next column, back to the top row
        row_d = '0;
        if (col_q == last_col_q) begin
          busy_d = 1'b0;
        end else begin
          col_d     = col_q + COORD_W'(1);
          colmod_d  = col_q + COORD_W'(1);
          rowbase_d = rowtop_q;
        end
      end else begin
        row_d     = row_q + COORD_W'(1);
        colmod_d  = (colmod_q == last_col_q) ? '0 : colmod_q + COORD_W'(1);
        rowbase_d = rowbase_q - ADDR_W'(width_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      colmod_q   <= '0;
      rowbase_q  <= '0;
      seq_q      <= '0;
      last_col_q <= '0;
      last_row_q <= '0;
      rowtop_q   <= '0;
      width_q    <= '0;
      mode_q     <= 1'b0;
      count_q    <= '0;
    end else begin
      busy_q     <= busy_d;
      col_q      <= col_d;
      row_q      <= row_d;
      colmod_q   <= colmod_d;
      rowbase_q  <= rowbase_d;
      seq_q      <= seq_d;
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      rowtop_q   <= rowtop_d;
      width_q    <= width_d;
      mode_q     <= mode_d;
      count_q    <= count_d;
    end
  end

  assign busy_o = busy_q;

endmodule

@@ design/matrix_transposition_cipher.sv @@
// ----------------------------------------------------------------------------
// matrix_transposition_cipher: block route transposition cipher
// Timing: a push gives its result in the next cycle; a pull gives its byte via
//   the registered read of the output buffer and then the result register.
// Throughput: one push per cycle while the result is not stalled; a pull holds
//   off further items until its byte is in the result register. A closing push
//   runs the walk generator, one walk position per cycle, and no item is taken.
// Reset clears control state only; the two byte buffers are not cleared.
// ----------------------------------------------------------------------------
module matrix_transposition_cipher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtc_pkg::PADDR_W-1:0] paddr,
  input  logic [mtc_pkg::PDATA_W-1:0] pwdata,
  output logic [mtc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // item channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mtc_pkg::mtc_in_t            in_data_i,
  // result channel
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output mtc_pkg::mtc_out_t           res_data_o
);
  import mtc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK
  } state_e;

  typedef enum logic {
    PH_LOAD,
    PH_EMIT
  } phase_e;

  mtc_cfg_t           cfg;
  side_t              width_c;
  side_t              height_c;
  logic [2*SIDE_W-1:0] cells_full;
  logic [CNT_W-1:0]   cells;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   loaded_count_q, loaded_count_d;
  logic [CNT_W-1:0]   emit_index_q, emit_index_d;
  logic               last_q, last_d;
  logic               res_valid_q, res_valid_d;
  mtc_out_t           res_q, res_d;
  logic               wr_pend_q, wr_pend_d;

  logic               in_fire;
  logic               is_push;
  logic               push_ok;
  logic               push_full;
  logic               load_we;
  logic               block_close;
  logic               pull_ok;
  logic               pull_last;
  logic [CNT_W-1:0]   count_inc;
  logic [CNT_W-1:0]   emit_inc;

  mtc_walk_cfg_t      walk_cfg;
  mtc_walk_step_t     walk_step;
  logic               walk_busy;

  logic [DATA_W-1:0]  load_mem    [MAX_CELLS];
  logic [DATA_W-1:0]  scatter_mem [MAX_CELLS];
  logic [DATA_W-1:0]  walk_data_q;
  logic [ADDR_W-1:0]  wr_addr_q;
  logic [DATA_W-1:0]  pull_data_q;

  mtc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // block capacity from the live keys; at most 64*64, which is MAX_CELLS
  assign width_c    = clamp_side(cfg.width);
  assign height_c   = clamp_side(cfg.height);
  assign cells_full = {{SIDE_W{1'b0}}, width_c} * {{SIDE_W{1'b0}}, height_c};
  assign cells      = cells_full[CNT_W-1:0];

  // item transfer decode
  assign in_stall_o  = (state_q != ST_IDLE) || (res_valid_q && res_stall_i);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign is_push     = (in_data_i.command == CMD_PUSH);
  assign push_ok     = in_fire && is_push && (phase_q == PH_LOAD);
  assign push_full   = (loaded_count_q >= cells);
  assign count_inc   = loaded_count_q + CNT_W'(1);
  assign load_we     = push_ok && !push_full;
  assign block_close = push_ok && (push_full || in_data_i.stream_end || (count_inc >= cells));
  assign pull_ok     = in_fire && !is_push && (phase_q == PH_EMIT) &&
                       (emit_index_q < loaded_count_q);
  assign emit_inc    = emit_index_q + CNT_W'(1);
  assign pull_last   = (emit_inc >= loaded_count_q);

  // block parameters sampled at close
  always_comb begin
    walk_cfg.width    = width_c;
    walk_cfg.height   = height_c;
    walk_cfg.decipher = cfg.decipher;
    walk_cfg.count    = push_full ? loaded_count_q : count_inc;
    walk_cfg.cells    = cells;
  end

  mtc_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (block_close),
    .cfg_i   (walk_cfg),
    .busy_o  (walk_busy),
    .step_o  (walk_step)
  );

  // load buffer: written by pushes, read by the walk
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      load_mem[loaded_count_q[ADDR_W-1:0]] <= in_data_i.data_in;
    end
    if (walk_step.valid) begin
      walk_data_q <= load_mem[walk_step.rd_addr];
      wr_addr_q   <= walk_step.wr_addr;
    end
  end

  // output buffer: written in the cycle after each walk read, read by pulls
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      scatter_mem[wr_addr_q] <= walk_data_q;
    end
    if (pull_ok) begin
      pull_data_q <= scatter_mem[emit_index_q[ADDR_W-1:0]];
    end
  end

  // control sequencer and result register
  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    loaded_count_d = loaded_count_q;
    emit_index_d   = emit_index_q;
    last_d         = last_q;
    res_d          = res_q;
    res_valid_d    = res_valid_q && res_stall_i;
    wr_pend_d      = walk_step.valid;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_push) begin
            res_d       = '0;
            res_valid_d = 1'b1;
            if (phase_q != PH_LOAD) begin
              res_d.rejected = 1'b1;
            end else begin
              if (!push_full) begin
                loaded_count_d = count_inc;
              end
              if (block_close) begin
                phase_d      = PH_EMIT;
                emit_index_d = '0;
                state_d      = ST_WALK;
              end
            end
          end else if (pull_ok) begin
            emit_index_d = emit_inc;
            last_d       = pull_last;
            if (pull_last) begin
              loaded_count_d = '0;
              emit_index_d   = '0;
              phase_d        = PH_LOAD;
            end
            state_d = ST_READ;
          end else begin
            res_d          = '0;
            res_d.rejected = 1'b1;
            res_valid_d    = 1'b1;
          end
        end
      end
      ST_READ: begin
        res_d.data_out   = pull_data_q;
        res_d.out_valid  = 1'b1;
        res_d.block_last = last_q;
        res_d.rejected   = 1'b0;
        res_valid_d      = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_WALK: begin
        // once the generator stops, the last write drains as this state is left
        if (!walk_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      phase_q        <= PH_LOAD;
      loaded_count_q <= '0;
      emit_index_q   <= '0;
      last_q         <= 1'b0;
      res_valid_q    <= 1'b0;
      res_q          <= '0;
      wr_pend_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      phase_q        <= phase_d;
      loaded_count_q <= loaded_count_d;
      emit_index_q   <= emit_index_d;
      last_q         <= last_d;
      res_valid_q    <= res_valid_d;
      res_q          <= res_d;
      wr_pend_q      <= wr_pend_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_q;

  // walk moves only happen while the sequencer waits on the walk
  a_walk_in_walk_state: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    walk_step.valid |-> (state_q == ST_WALK)
  ) else $error("walk move outside of walk state");

  // a pending pull read always turns into a result on the next cycle
  a_read_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (res_valid_o && res_data_o.out_valid)
  ) else $error("pull read did not produce a result");

  // an emitting block always holds at least one byte
  a_emit_nonempty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EMIT) |-> (loaded_count_q != '0)
  ) else $error("emitting phase with an empty block");

  // the loaded count never exceeds the buffer depth
  a_count_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    loaded_count_q <= CNT_W'(MAX_CELLS)
  ) else $error("loaded count beyond buffer depth");

endmodule
